// ===== sv/ready_queue_select_assert.svh =====
// Assertion macros for the ready queue. Each macro expects signals named clk and rst_n
// in the scope where it is used.
`ifndef READY_QUEUE_SELECT_ASSERT_SVH
`define READY_QUEUE_SELECT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define RQS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define RQS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RQS_ASSERT(lbl, prop, msg)
`define RQS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== sv/rqs_pkg.sv =====
`timescale 1ns / 1ps

package rqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int KEY_W   = (BURST_W > PRIO_W) ? BURST_W : PRIO_W;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    localparam logic [MODE_W-1:0] POL_FIFO = MODE_W'(0);
    localparam logic [MODE_W-1:0] POL_SJF  = MODE_W'(1);
    localparam logic [MODE_W-1:0] POL_PR   = MODE_W'(2);

    localparam logic [STAT_W-1:0] ST_OK    = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_EMPTY = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    // Low FILL_W bits of an entry count, zero-extended where the count is narrower.
    function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+FILL_W-1:0] wide;
        wide = {{FILL_W{1'b0}}, cnt};
        return wide[FILL_W-1:0];
    endfunction

endpackage

// ===== sv/rqs_entry_ram.sv =====
`timescale 1ns / 1ps

module rqs_entry_ram (
    input  logic                       clk,
    input  rqs_pkg::ram_wr_t           wr,
    input  logic [rqs_pkg::IDX_W-1:0]  raddr,
    output rqs_pkg::entry_t            rdata
);
    import rqs_pkg::*;

    // Entry storage; contents are undefined until written.
    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ready_queue_select.sv =====
// ready_queue_select: bounded ready queue with FIFO, shortest-burst or highest-priority removal.
// Enqueue and empty dequeue: the registered result strobe comes in the cycle after acceptance.
// Dequeue of n entries taking slot k: a scan of the held entries (slot zero only under FIFO),
// then a shift of the later entries when k < n-1, then the strobe, all through the one RAM read port.
// Reset (rst_n low, asynchronous) empties the queue and selects FIFO; no clearing pass.
// Results last one cycle on done and cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "ready_queue_select_assert.svh"

module ready_queue_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [rqs_pkg::ID_W-1:0]      proc_id,
    input  logic [rqs_pkg::PRIO_W-1:0]    prio_in,
    input  logic [rqs_pkg::BURST_W-1:0]   burst_in,
    input  logic                          policy_we,
    input  logic [rqs_pkg::MODE_W-1:0]    policy_wdata,
    output logic                          done,
    output logic                          took_entry,
    output logic [rqs_pkg::ID_W-1:0]      out_id,
    output logic [rqs_pkg::PRIO_W-1:0]    out_prio,
    output logic [rqs_pkg::BURST_W-1:0]   out_burst,
    output logic [rqs_pkg::STAT_W-1:0]    status,
    output logic [rqs_pkg::FILL_W-1:0]    fill_level
);
    import rqs_pkg::*;

    // The sequencer idles waiting for a transfer, scans the held entries one per cycle
    // through a single comparator (only slot zero under FIFO), then closes any gap left by the removed entry.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t             state_reg,     state_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [MODE_W-1:0]  mode_reg,      mode_next;
    logic [IDX_W-1:0]   scan_idx_reg,  scan_idx_next;
    logic [IDX_W-1:0]   scan_last_reg, scan_last_next;
    logic [IDX_W-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic               cmp_vld_reg,   cmp_vld_next;
    logic [IDX_W-1:0]   last_idx_reg,  last_idx_next;
    logic [IDX_W-1:0]   best_idx_reg,  best_idx_next;
    entry_t             best_reg,      best_next;
    logic [IDX_W-1:0]   sh_rd_reg,     sh_rd_next;
    logic               sh_act_reg,    sh_act_next;
    logic               wr_vld_reg,    wr_vld_next;
    logic [IDX_W-1:0]   wr_addr_reg,   wr_addr_next;
    logic               done_reg,      done_next;
    logic               took_reg,      took_next;
    entry_t             res_reg,       res_next;
    logic [STAT_W-1:0]  status_reg,    status_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;

    logic               accept;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   cnt_m1_idx;
    entry_t             rd_data;
    ram_wr_t            ram_wr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [KEY_W-1:0]   cmp_a;
    logic [KEY_W-1:0]   cmp_b;
    logic               cmp_less;
    logic               take;
    logic [IDX_W-1:0]   best_sel_idx;
    entry_t             best_sel;
    logic               scan_end;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign cnt_m1_idx = cnt_m1[IDX_W-1:0];

    rqs_entry_ram u_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Shared comparator. For shortest burst the fresh entry wins when its burst is
    // strictly smaller; for highest priority when its priority is strictly larger. Ties
    // therefore keep the older entry. Any other policy code never replaces slot zero.
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        case (mode_reg)
            POL_SJF:
            begin
                cmp_a = KEY_W'(rd_data.burst);
                cmp_b = KEY_W'(best_reg.burst);
            end
            POL_PR:
            begin
                cmp_a = KEY_W'(best_reg.prio);
                cmp_b = KEY_W'(rd_data.prio);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_less     = (cmp_a < cmp_b);
    assign take         = cmp_vld_reg && ((cmp_idx_reg == '0) || cmp_less);
    assign best_sel_idx = take ? cmp_idx_reg : best_idx_reg;
    assign best_sel     = take ? rd_data : best_reg;
    assign scan_end     = cmp_vld_reg && (cmp_idx_reg == scan_last_reg);

    // The read port follows the scan pointer, or the shift pointer while compacting.
    assign ram_raddr = (state_reg == S_SHIFT) ? sh_rd_reg : scan_idx_reg;

    // A single write port: enqueue appends at the count, compaction moves each entry
    // down one slot the cycle after it has been read.
    always_comb
    begin
        ram_wr.en         = 1'b0;
        ram_wr.addr       = count_reg[IDX_W-1:0];
        ram_wr.data.id    = proc_id;
        ram_wr.data.prio  = prio_in;
        ram_wr.data.burst = burst_in;
        if (state_reg == S_SHIFT)
        begin
            ram_wr.en   = wr_vld_reg;
            ram_wr.addr = wr_addr_reg;
            ram_wr.data = rd_data;
        end
        else if (state_reg == S_IDLE)
        begin
            ram_wr.en = accept && (req_type == REQ_ENQ) && (count_reg != FULL_CNT);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        mode_next      = policy_we ? policy_wdata : mode_reg;
        scan_idx_next  = scan_idx_reg;
        scan_last_next = scan_last_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        last_idx_next  = last_idx_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        sh_rd_next     = sh_rd_reg;
        sh_act_next    = sh_act_reg;
        wr_vld_next    = 1'b0;
        wr_addr_next   = wr_addr_reg;
        done_next      = 1'b0;
        took_next      = took_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    took_next = 1'b0;
                    res_next  = '0;
                    if (req_type == REQ_ENQ)
                    begin
                        done_next = 1'b1;
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = ST_FULL;
                            fill_next   = fill_of(count_reg);
                        end
                        else
                        begin
                            status_next = ST_OK;
                            count_next  = count_reg + CNT_W'(1);
                            fill_next   = fill_of(count_reg + CNT_W'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_EMPTY;
                        fill_next   = '0;
                    end
                    else
                    begin
                        state_next    = S_SCAN;
                        scan_idx_next = '0;
                        cmp_idx_next  = '0;
                        cmp_vld_next  = 1'b0;
                        last_idx_next = cnt_m1_idx;
                        if ((mode_reg == POL_SJF) || (mode_reg == POL_PR))
                        begin
                            scan_last_next = cnt_m1_idx;
                        end
                        else
                        begin
                            scan_last_next = '0;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                if (scan_idx_reg != scan_last_reg)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                best_idx_next = best_sel_idx;
                best_next     = best_sel;
                if (scan_end)
                begin
                    if (best_sel_idx == last_idx_reg)
                    begin
                        // The newest entry leaves, so nothing needs to move.
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        took_next   = 1'b1;
                        res_next    = best_sel;
                        status_next = ST_OK;
                        count_next  = cnt_m1;
                        fill_next   = fill_of(cnt_m1);
                    end
                    else
                    begin
                        state_next  = S_SHIFT;
                        sh_rd_next  = best_sel_idx + IDX_W'(1);
                        sh_act_next = 1'b1;
                    end
                end
            end

            S_SHIFT:
            begin
                if (sh_act_reg)
                begin
                    wr_vld_next  = 1'b1;
                    wr_addr_next = sh_rd_reg - IDX_W'(1);
                    if (sh_rd_reg == last_idx_reg)
                    begin
                        sh_act_next = 1'b0;
                    end
                    else
                    begin
                        sh_rd_next = sh_rd_reg + IDX_W'(1);
                    end
                end
                if (wr_vld_reg && !sh_act_reg)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    took_next   = 1'b1;
                    res_next    = best_reg;
                    status_next = ST_OK;
                    count_next  = cnt_m1;
                    fill_next   = fill_of(cnt_m1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mode_reg      <= POL_FIFO;
            scan_idx_reg  <= '0;
            scan_last_reg <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            last_idx_reg  <= '0;
            best_idx_reg  <= '0;
            best_reg      <= '0;
            sh_rd_reg     <= '0;
            sh_act_reg    <= 1'b0;
            wr_vld_reg    <= 1'b0;
            wr_addr_reg   <= '0;
            done_reg      <= 1'b0;
            took_reg      <= 1'b0;
            res_reg       <= '0;
            status_reg    <= ST_OK;
            fill_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            scan_idx_reg  <= scan_idx_next;
            scan_last_reg <= scan_last_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            last_idx_reg  <= last_idx_next;
            best_idx_reg  <= best_idx_next;
            best_reg      <= best_next;
            sh_rd_reg     <= sh_rd_next;
            sh_act_reg    <= sh_act_next;
            wr_vld_reg    <= wr_vld_next;
            wr_addr_reg   <= wr_addr_next;
            done_reg      <= done_next;
            took_reg      <= took_next;
            res_reg       <= res_next;
            status_reg    <= status_next;
            fill_reg      <= fill_next;
        end
    end

    assign done       = done_reg;
    assign took_entry = took_reg;
    assign out_id     = res_reg.id;
    assign out_prio   = res_reg.prio;
    assign out_burst  = res_reg.burst;
    assign status     = status_reg;
    assign fill_level = fill_reg;

    // A returned entry always comes with a good status.
    `RQS_ASSERT(a_took_ok, done && took_entry |-> status == ST_OK,
                "entry returned with bad status")
    // An accepted enqueue into a queue with room grows the count by one.
    `RQS_ASSERT(a_enq_count,
                start && !busy && req_type == REQ_ENQ && count_reg != FULL_CNT
                |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)),
                "enqueue did not grow count")
    // Every dequeue that occupied the sequencer ends with a result strobe.
    `RQS_ASSERT(a_busy_done, $fell(busy) |-> done, "busy dropped without a result")
    // An empty dequeue reports an empty queue and returns nothing.
    `RQS_ASSERT(a_empty_res, done && status == ST_EMPTY |-> !took_entry && fill_level == '0,
                "empty dequeue result inconsistent")
    // Once reset has been seen, the block sits idle with no result pending.
    `RQS_ASSERT_RST(a_rst_quiet, !rst_n |=> !done && !busy, "activity during reset")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the ready queue. Requests are sent as command-style
// transfers (start held until the block drops busy), and every request produces exactly
// one result transfer, strobed on done. A behavioural model of the queue predicts each
// result at the moment its request is accepted, and a monitor compares every result
// transfer with the oldest prediction, field by field.
module testbench;

    import rqs_pkg::*;

    // The one policy code that has no meaning of its own; the block treats it as FIFO.
    localparam logic [MODE_W-1:0] POL_SPARE = MODE_W'(3);

    localparam int GAP_MAX         = 5;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 157;
    // The drain wait covers the longest dequeue, which scans and shifts a full queue.
    localparam int DRAIN_CYCLES    = 2 * QUEUE_DEPTH + 8;
    localparam int LIMIT_NS        = 10_000_000;

    // One result transfer as seen on the output ports.
    typedef struct packed {
        logic               took;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [STAT_W-1:0]  status;
        logic [FILL_W-1:0]  fill;
    } result_t;

    // One row of the directed part. Where typed is set, res holds the expected result
    // written out by hand; otherwise the queue model supplies it.
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic               req;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        bit                 typed;
        result_t            res;
    } stim_row_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               req_type     = REQ_ENQ;
    logic [ID_W-1:0]    proc_id      = '0;
    logic [PRIO_W-1:0]  prio_in      = '0;
    logic [BURST_W-1:0] burst_in     = '0;
    logic               policy_we    = 1'b0;
    logic [MODE_W-1:0]  policy_wdata = POL_FIFO;
    logic               done;
    logic               took_entry;
    logic [ID_W-1:0]    out_id;
    logic [PRIO_W-1:0]  out_prio;
    logic [BURST_W-1:0] out_burst;
    logic [STAT_W-1:0]  status;
    logic [FILL_W-1:0]  fill_level;

    // Model state: the entries held in arrival order, oldest first, and the policy.
    entry_t            held_entries[$];
    logic [MODE_W-1:0] policy_sel = POL_FIFO;

    result_t   expected_results[$];
    stim_row_t directed_rows[$];

    int  failures        = 0;
    int  requests_sent   = 0;
    int  entries_removed = 0;
    int  empty_dequeues  = 0;
    int  dropped_enqueues = 0;
    int  policy_writes   = 0;
    bit  idle_enabled    = 1'b1;

    ready_queue_select u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .proc_id      (proc_id),
        .prio_in      (prio_in),
        .burst_in     (burst_in),
        .policy_we    (policy_we),
        .policy_wdata (policy_wdata),
        .done         (done),
        .took_entry   (took_entry),
        .out_id       (out_id),
        .out_prio     (out_prio),
        .out_burst    (out_burst),
        .status       (status),
        .fill_level   (fill_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs and a result never arrives.
    initial
    begin
        #(LIMIT_NS);
        $display("testbench failed");
        $finish;
    end

    // Queue model. An enqueue appends unless the queue is full; a dequeue removes the
    // entry chosen by the policy, the oldest winning every tie, and the queue closes up
    // behind it so that arrival order is kept.
    function automatic result_t predict_request(input logic req,
                                                input logic [ID_W-1:0] id,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [BURST_W-1:0] burst);
        result_t r;
        entry_t  e;
        int      pick;
        r = '0;
        r.status = ST_OK;
        if (req == REQ_ENQ)
        begin
            if (held_entries.size() >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                e.id    = id;
                e.prio  = prio;
                e.burst = burst;
                held_entries.push_back(e);
            end
        end
        else if (held_entries.size() == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            pick = 0;
            for (int i = 1; i < held_entries.size(); i++)
            begin
                // Strict comparisons, so a later entry never displaces an equal older one.
                if (policy_sel == POL_SJF && held_entries[i].burst < held_entries[pick].burst)
                    pick = i;
                else if (policy_sel == POL_PR && held_entries[i].prio > held_entries[pick].prio)
                    pick = i;
            end
            e = held_entries[pick];
            held_entries.delete(pick);
            r.took  = 1'b1;
            r.id    = e.id;
            r.prio  = e.prio;
            r.burst = e.burst;
        end
        r.fill = FILL_W'(held_entries.size());
        return r;
    endfunction

    // Values for priority and burst: a small range to force ties, the two extremes, or
    // anything at all.
    function automatic int rand_key(input int max_value);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(0, 1) ? max_value : 0;
            default: return $urandom_range(0, max_value);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected_value,
                                        input logic [31:0] actual_value);
        if (expected_value !== actual_value)
        begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, expected_value, actual_value);
            failures++;
        end
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] mode, input logic req,
                           input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                           input logic [BURST_W-1:0] burst,
                           input bit typed = 1'b0, input result_t res = '0);
        stim_row_t row;
        row.mode  = mode;
        row.req   = req;
        row.id    = id;
        row.prio  = prio;
        row.burst = burst;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    // Sends one request. Start is left high after the transfer, so that a following
    // request with no gap goes out back to back; it is lowered only when a gap is drawn,
    // when the policy is written, or at the end of the run.
    task automatic transfer_request(input logic req, input logic [ID_W-1:0] id,
                                    input logic [PRIO_W-1:0] prio,
                                    input logic [BURST_W-1:0] burst,
                                    input bit typed, input result_t typed_res);
        int      gap;
        result_t exp;
        gap = idle_enabled ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        proc_id  <= id;
        prio_in  <= prio;
        burst_in <= burst;
        @(posedge clk);
        while (busy) @(posedge clk);
        // The transfer took place at this edge.
        exp = predict_request(req, id, prio, burst);
        if (typed)
            exp = typed_res;
        expected_results.push_back(exp);
        requests_sent++;
        if (exp.took)
            entries_removed++;
        if (exp.status == ST_EMPTY)
            empty_dequeues++;
        if (exp.status == ST_FULL)
            dropped_enqueues++;
    endtask

    // The policy register is only written with the block idle: every result in and busy low.
    task automatic set_policy(input logic [MODE_W-1:0] mode);
        start <= 1'b0;
        while (expected_results.size() != 0 || busy) @(posedge clk);
        policy_we    <= 1'b1;
        policy_wdata <= mode;
        @(posedge clk);
        policy_we  <= 1'b0;
        policy_sel = mode;
        policy_writes++;
    endtask

    // Result monitor. Outputs are sampled at the rising edge, before the block's own
    // updates for that edge take effect, so the values seen are those of the strobed cycle.
    always @(posedge clk)
    begin : result_monitor
        result_t oldest;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                failures++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                check_field("took_entry", 32'(oldest.took), 32'(took_entry));
                check_field("out_id", 32'(oldest.id), 32'(out_id));
                check_field("out_prio", 32'(oldest.prio), 32'(out_prio));
                check_field("out_burst", 32'(oldest.burst), 32'(out_burst));
                check_field("status", 32'(oldest.status), 32'(status));
                check_field("fill_level", 32'(oldest.fill), 32'(fill_level));
            end
        end
    end

    initial
    begin : stimulus
        logic [MODE_W-1:0] phase_modes[4];
        logic [MODE_W-1:0] mode;
        int                enq_pct;
        logic              req;

        phase_modes = '{POL_FIFO, POL_SJF, POL_PR, POL_SPARE};

        // Directed part. The first rows have results that follow straight from reset and
        // from the extremes of the fields; the policy rows after them build small queues
        // with deliberate ties and leave the choice of entry to the model.
        add_row(POL_FIFO, REQ_DEQ, 16'h0000, 8'h00, 16'h0000, 1'b1,
                '{1'b0, 16'h0000, 8'h00, 16'h0000, ST_EMPTY, 5'd0});
        add_row(POL_FIFO, REQ_ENQ, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1,
                '{1'b0, 16'h0000, 8'h00, 16'h0000, ST_OK, 5'd1});
        add_row(POL_FIFO, REQ_ENQ, 16'h0000, 8'h00, 16'h0000, 1'b1,
                '{1'b0, 16'h0000, 8'h00, 16'h0000, ST_OK, 5'd2});
        // The request fields of a dequeue carry junk, which the block must ignore.
        add_row(POL_FIFO, REQ_DEQ, 16'hAAAA, 8'h55, 16'h5555, 1'b1,
                '{1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, ST_OK, 5'd1});
        add_row(POL_FIFO, REQ_DEQ, 16'h5555, 8'hAA, 16'hAAAA, 1'b1,
                '{1'b1, 16'h0000, 8'h00, 16'h0000, ST_OK, 5'd0});
        add_row(POL_FIFO, REQ_ENQ, 16'h0101, 8'h10, 16'h0300);
        add_row(POL_FIFO, REQ_ENQ, 16'h0202, 8'h40, 16'h0007);
        add_row(POL_FIFO, REQ_ENQ, 16'h0303, 8'h40, 16'h0007);
        add_row(POL_FIFO, REQ_ENQ, 16'h0404, 8'h00, 16'hFFFF);
        add_row(POL_FIFO, REQ_ENQ, 16'h0505, 8'hFF, 16'h0000);
        add_row(POL_SJF,  REQ_DEQ, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_row(POL_SJF,  REQ_DEQ, 16'h0000, 8'h00, 16'h0000);
        add_row(POL_PR,   REQ_DEQ, 16'h1234, 8'h12, 16'h1234);
        add_row(POL_PR,   REQ_ENQ, 16'h0606, 8'h10, 16'h0300);
        add_row(POL_PR,   REQ_DEQ, 16'h0000, 8'h00, 16'h0000);
        add_row(POL_SPARE, REQ_DEQ, 16'h0000, 8'h00, 16'h0000);
        add_row(POL_SPARE, REQ_ENQ, 16'h0707, 8'h80, 16'h0001);
        add_row(POL_SJF,  REQ_DEQ, 16'h0000, 8'h00, 16'h0000);
        add_row(POL_FIFO, REQ_DEQ, 16'h0000, 8'h00, 16'h0000);
        add_row(POL_FIFO, REQ_DEQ, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1,
                '{1'b0, 16'h0000, 8'h00, 16'h0000, ST_EMPTY, 5'd0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != policy_sel)
                set_policy(directed_rows[i].mode);
            transfer_request(directed_rows[i].req, directed_rows[i].id, directed_rows[i].prio,
                             directed_rows[i].burst, directed_rows[i].typed,
                             directed_rows[i].res);
        end

        // Random part. The phases alternate between filling and draining so that the queue
        // keeps reaching both full and empty; the first phase fills hard to force dropped
        // enqueues early. The first four phases walk every policy code, the rest draw one.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mode = (phase < 4) ? phase_modes[phase] : phase_modes[$urandom_range(0, 3)];
            set_policy(mode);
            if (phase == 0)
                enq_pct = 92;
            else if (phase % 2 == 0)
                enq_pct = $urandom_range(55, 92);
            else
                enq_pct = $urandom_range(10, 45);
            // Roughly one phase in four runs with no gaps between requests.
            idle_enabled = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                req = ($urandom_range(1, 100) <= enq_pct) ? REQ_ENQ : REQ_DEQ;
                transfer_request(req, ID_W'($urandom_range(0, 16'hFFFF)),
                                 PRIO_W'(rand_key(8'hFF)), BURST_W'(rand_key(16'hFFFF)),
                                 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d policy writes, all four policy codes included.",
                 requests_sent, policy_writes);
        $display("Entries removed: %0d, dequeues on empty: %0d, enqueues dropped when full: %0d.",
                 entries_removed, empty_dequeues, dropped_enqueues);
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== ready_queue_select.f =====
+incdir+sv
sv/rqs_pkg.sv
sv/rqs_entry_ram.sv
sv/ready_queue_select.sv
dv/testbench.sv
